@@ design/hybrid_ell_coo_splitter_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the hybrid ELL/COO splitter
// Shared concurrent assertion forms, clocked on clock.
// ----------------------------------------------------------------------------
`ifndef HYBRID_ELL_COO_SPLITTER_TOP_DEFINES_SVH
`define HYBRID_ELL_COO_SPLITTER_TOP_DEFINES_SVH

// check outside reset only
`define HECS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// check on every edge, reset included
`define HECS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/hecs_pkg.sv @@
// ----------------------------------------------------------------------------
// hecs_pkg
// Widths, reset values and register codes of the hybrid ELL/COO splitter.
// ----------------------------------------------------------------------------
package hecs_pkg;

   localparam int ROW_W      = 12;
   localparam int COL_W      = 16;
   localparam int VAL_W      = 32;
   localparam int FILL_W     = 16;
   localparam int ADDR_W     = 20;
   localparam int NUM_ROWS_W = 13;
   localparam int ELL_W_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = NUM_ROWS_W;

   localparam int DEF_MAX_ROWS = 4096;

   localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST     = 13'd4096;
   localparam logic [ELL_W_W-1:0]    ELL_WIDTH_RST    = 8'd16;
   localparam logic                  COLUMN_MAJOR_RST = 1'b1;

   localparam logic [FILL_W-1:0] FILL_MAX = '1;
   localparam logic [ADDR_W-1:0] OVF_MAX  = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_ROWS     = 2'd0,
      CSR_ELL_WIDTH    = 2'd1,
      CSR_COLUMN_MAJOR = 2'd2
   } csr_index_type;

endpackage

@@ design/hecs_ifs.sv @@
// ----------------------------------------------------------------------------
// hecs_req_if / hecs_rsp_if
// Valid/ready channels carrying entry words in and placement words out.
// ----------------------------------------------------------------------------
interface hecs_req_if;
   import hecs_pkg::*;

   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] row_index;
   logic [COL_W-1:0] col_index;
   logic [VAL_W-1:0] value_bits;

   modport source (output valid, output row_index, output col_index,
                   output value_bits, input ready);
   modport sink   (input valid, input row_index, input col_index,
                   input value_bits, output ready);
endinterface

interface hecs_rsp_if;
   import hecs_pkg::*;

   logic              valid;
   logic              ready;
   logic              to_overflow;
   logic [ADDR_W-1:0] ell_address;
   logic [ADDR_W-1:0] overflow_slot;
   logic [ROW_W-1:0]  out_row;
   logic [COL_W-1:0]  out_col;
   logic [VAL_W-1:0]  out_value;

   modport source (output valid, output to_overflow, output ell_address,
                   output overflow_slot, output out_row, output out_col,
                   output out_value, input ready);
   modport sink   (input valid, input to_overflow, input ell_address,
                   input overflow_slot, input out_row, input out_col,
                   input out_value, output ready);
endinterface

@@ design/hecs_ram.sv @@
// ----------------------------------------------------------------------------
// hecs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hecs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/hybrid_ell_coo_splitter_top.sv @@
// ----------------------------------------------------------------------------
// hybrid_ell_coo_splitter_top
// Splits row-sorted sparse entries between an ELL store and a COO list.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one entry word (row, column, value) per handshake; rsp_bus
//   returns one placement word per entry, in order: either an ELL slot address
//   or a COO list position, with the entry echoed alongside.
//   csr_* writes num_rows, ell_width and column_major; write only while idle.
// Pipeline and throughput:
//   An accepted word passes the lookup stage and output registers to rsp_bus.
//   One word per cycle is sustained while rsp_bus.ready is high; the per-row
//   fill counter lives in a RAM with registered read, and the read-modify-write
//   keeps pace by forwarding the last written counter to the next read of the row.
// Reset:
//   Reset clears the overflow count and restores the register defaults, then
//   a clearing pass writes zero to every fill counter, one per cycle;
//   req_bus.ready stays low during the pass.
// Stalls:
//   A placement word waits in the output register while rsp_bus.ready is low;
//   one more entry may sit in the lookup stage behind it, after which
//   req_bus.ready drops until the output register is taken.
// ----------------------------------------------------------------------------
module hybrid_ell_coo_splitter_top #(
   parameter int MAX_ROWS = hecs_pkg::DEF_MAX_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [hecs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hecs_pkg::CSR_DATA_W-1:0] csr_wdata,
   hecs_req_if.sink                        req_bus,
   hecs_rsp_if.source                      rsp_bus
);
   import hecs_pkg::*;

   localparam int RAM_AW = $clog2(MAX_ROWS);
   localparam logic [RAM_AW-1:0] LAST_IDX = RAM_AW'(MAX_ROWS - 1);
   localparam int PROD_W = FILL_W + NUM_ROWS_W;

   // Fold a row onto the counter array: row modulo MAX_ROWS by
   // conditional subtraction of shifted copies of the depth.
   function automatic logic [ROW_W-1:0] row_fold(input logic [ROW_W-1:0] r);
      logic [ROW_W-1:0] acc;
      acc = r;
      for (int k = ROW_W - 1; k >= 0; k--) begin
         if ((MAX_ROWS << k) < (1 << ROW_W)) begin
            if (acc >= ROW_W'(MAX_ROWS << k)) begin
               acc = acc - ROW_W'(MAX_ROWS << k);
            end
         end
      end
      return acc;
   endfunction

   // configuration registers
   logic [NUM_ROWS_W-1:0] num_rows_ff;
   logic [ELL_W_W-1:0]    ell_width_ff;
   logic                  column_major_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff     <= NUM_ROWS_RST;
         ell_width_ff    <= ELL_WIDTH_RST;
         column_major_ff <= COLUMN_MAJOR_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_ROWS:     num_rows_ff     <= csr_wdata;
            CSR_ELL_WIDTH:    ell_width_ff    <= csr_wdata[ELL_W_W-1:0];
            CSR_COLUMN_MAJOR: column_major_ff <= csr_wdata[0];
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   // clearing pass over the fill counters
   logic              clearing_ff, clearing_in;
   logic [RAM_AW-1:0] clr_idx_ff, clr_idx_in;

   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         if (clr_idx_ff == LAST_IDX) begin
            clearing_in = 1'b0;
         end else begin
            clr_idx_in = clr_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic s1_adv;
   logic req_take;

   assign s1_adv   = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !clearing_ff && (!s1_valid_ff || s1_adv);
   assign req_take = req_bus.valid && req_bus.ready;

   // lookup stage: hold the entry while the fill counter is read
   logic [ROW_W-1:0]  s1_row_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [VAL_W-1:0]  s1_val_ff;
   logic [RAM_AW-1:0] s1_slot_ff;
   logic [RAM_AW-1:0] req_slot;

   assign req_slot = RAM_AW'(row_fold(req_bus.row_index));

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_row_ff  <= req_bus.row_index;
         s1_col_ff  <= req_bus.col_index;
         s1_val_ff  <= req_bus.value_bits;
         s1_slot_ff <= req_slot;
      end
   end

   // fill counter RAM and forwarding of the latest write
   logic              ram_wr_en;
   logic [RAM_AW-1:0] ram_wr_addr;
   logic [FILL_W-1:0] ram_wr_data;
   logic [FILL_W-1:0] ram_rd_data;
   logic              fwd_valid_ff;
   logic [RAM_AW-1:0] fwd_slot_ff;
   logic [FILL_W-1:0] fwd_fill_ff;
   logic [FILL_W-1:0] fill_cur;
   logic [FILL_W-1:0] fill_next;

   hecs_ram #(
      .WIDTH (FILL_W),
      .DEPTH (MAX_ROWS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_take),
      .rd_addr (req_slot),
      .rd_data (ram_rd_data)
   );

   // The RAM read of the entry in the lookup stage may predate the write of
   // the entry just ahead of it; take that write when the counter slots match.
   assign fill_cur = (fwd_valid_ff && (fwd_slot_ff == s1_slot_ff)) ? fwd_fill_ff
                                                                    : ram_rd_data;
   assign fill_next = (fill_cur == FILL_MAX) ? fill_cur : fill_cur + 1'b1;

   always_comb begin
      if (clearing_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_idx_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_adv;
         ram_wr_addr = s1_slot_ff;
         ram_wr_data = fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         fwd_slot_ff <= s1_slot_ff;
         fwd_fill_ff <= fill_next;
      end
   end

   // placement: one shared multiplier serves both layouts
   //   column-major: row + fill * num_rows
   //   row-major:    row * ell_width + fill
   logic              is_ovf;
   logic [FILL_W-1:0] mul_a;
   logic [NUM_ROWS_W-1:0] mul_b;
   logic [FILL_W-1:0] addend;
   logic [PROD_W-1:0] product;
   logic [PROD_W-1:0] addr_sum;
   logic [ADDR_W-1:0] ell_addr;

   assign is_ovf   = fill_cur >= FILL_W'(ell_width_ff);
   assign mul_a    = column_major_ff ? fill_cur : FILL_W'(s1_row_ff);
   assign mul_b    = column_major_ff ? num_rows_ff : NUM_ROWS_W'(ell_width_ff);
   assign addend   = column_major_ff ? FILL_W'(s1_row_ff) : fill_cur;
   assign product  = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign addr_sum = product + PROD_W'(addend);
   assign ell_addr = addr_sum[ADDR_W-1:0];

   // overflow count, saturating
   logic [ADDR_W-1:0] ovf_count_ff, ovf_count_in;

   always_comb begin
      ovf_count_in = ovf_count_ff;
      if (s1_adv && is_ovf && (ovf_count_ff != OVF_MAX)) begin
         ovf_count_in = ovf_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_count_ff <= '0;
      end else begin
         ovf_count_ff <= ovf_count_in;
      end
   end

   // stage valids
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // output register: hold the word until the receiver takes it
   logic              out_ovf_ff;
   logic [ADDR_W-1:0] out_addr_ff;
   logic [ADDR_W-1:0] out_oslot_ff;
   logic [ROW_W-1:0]  out_row_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [VAL_W-1:0]  out_val_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_ovf_ff   <= is_ovf;
         out_addr_ff  <= is_ovf ? '0 : ell_addr;
         out_oslot_ff <= is_ovf ? ovf_count_ff : '0;
         out_row_ff   <= s1_row_ff;
         out_col_ff   <= s1_col_ff;
         out_val_ff   <= s1_val_ff;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.to_overflow   = out_ovf_ff;
   assign rsp_bus.ell_address   = out_addr_ff;
   assign rsp_bus.overflow_slot = out_oslot_ff;
   assign rsp_bus.out_row       = out_row_ff;
   assign rsp_bus.out_col       = out_col_ff;
   assign rsp_bus.out_value     = out_val_ff;

endmodule

@@ design/hecs_checker.sv @@
// ----------------------------------------------------------------------------
// hecs_checker
// Port-level checks of the hybrid ELL/COO splitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "hybrid_ell_coo_splitter_top_defines.svh"

module hecs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          to_overflow,
   input logic [hecs_pkg::ADDR_W-1:0]   ell_address,
   input logic [hecs_pkg::ADDR_W-1:0]   overflow_slot,
   input logic [hecs_pkg::ROW_W-1:0]    out_row,
   input logic [hecs_pkg::COL_W-1:0]    out_col,
   input logic [hecs_pkg::VAL_W-1:0]    out_value
);
   import hecs_pkg::*;

   // no entry is taken in the cycle after reset: the clearing pass runs
   `HECS_ASSERT_ALWAYS(a_no_take_after_reset, reset |=> !req_ready,
      "entry accepted while fill counters are being cleared")

   // every accepted word is followed by a visible result on rsp_bus
   `HECS_ASSERT(a_result_latency, (req_valid && req_ready) |-> ##2 rsp_valid,
      "no result two cycles after an accepted entry")

   // a placement word names either an ELL slot or a COO position, not both
   `HECS_ASSERT(a_exclusive_fields,
      rsp_valid |-> ((!to_overflow || (ell_address == '0)) &&
                     (to_overflow || (overflow_slot == '0))),
      "ELL address and COO position both set")

   // a stalled result word holds
   `HECS_ASSERT(a_stall_hold,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(to_overflow) &&
         $stable(ell_address) && $stable(overflow_slot) && $stable(out_row) &&
         $stable(out_col) && $stable(out_value)),
      "result word changed while stalled")

endmodule

bind hybrid_ell_coo_splitter_top hecs_checker u_hecs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .to_overflow   (rsp_bus.to_overflow),
   .ell_address   (rsp_bus.ell_address),
   .overflow_slot (rsp_bus.overflow_slot),
   .out_row       (rsp_bus.out_row),
   .out_col       (rsp_bus.out_col),
   .out_value     (rsp_bus.out_value)
);
